// ===== hw/rtl/edc_pkg.sv =====
// Shared types, register indexes and constant tables for the event decay convolution block.
package edc_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 48;
  localparam int VALUE_W    = 32;
  localparam int FACTOR_W   = 17;
  localparam int TERMS      = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_THREE  = 3'd4;

  typedef struct packed {
    logic clear;
    logic load_event;
    logic calc_addr;
    logic mem_read;
    logic start_decay;
    logic mul;
    logic finish;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic decay_done;
    logic out_free;
    logic last_cell;
  } stat_t;

  // floor(2^31 / k), Taylor term divide by reciprocal multiply
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd1:    m = 32'd2147483648;
      4'd2:    m = 32'd1073741824;
      4'd3:    m = 32'd715827882;
      4'd4:    m = 32'd536870912;
      4'd5:    m = 32'd429496729;
      4'd6:    m = 32'd357913941;
      4'd7:    m = 32'd306783378;
      4'd8:    m = 32'd268435456;
      4'd9:    m = 32'd238609294;
      4'd10:   m = 32'd214748364;
      4'd11:   m = 32'd195225786;
      4'd12:   m = 32'd178956970;
      4'd13:   m = 32'd165191049;
      4'd14:   m = 32'd153391689;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/edc_decay.sv =====
// Iterative decay factor unit: exp(-rate*dt/2^32) in Q1.16 by Taylor series and squaring.
module edc_decay (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dt,
  input  logic [31:0] rate,
  output logic        done,
  output logic [16:0] factor
);
  import edc_pkg::*;

  localparam logic [3:0] D_IDLE  = 4'd0;
  localparam logic [3:0] D_E1    = 4'd1;
  localparam logic [3:0] D_E2    = 4'd2;
  localparam logic [3:0] D_T1    = 4'd3;
  localparam logic [3:0] D_T2    = 4'd4;
  localparam logic [3:0] D_T3    = 4'd5;
  localparam logic [3:0] D_CLAMP = 4'd6;
  localparam logic [3:0] D_SQ    = 4'd7;
  localparam logic [3:0] D_RND   = 4'd8;
  localparam logic [3:0] D_DONE  = 4'd9;

  localparam logic signed [33:0] ONE_Q31 = 34'sd2147483648;

  logic [3:0]         state_r, state_nxt;
  logic [35:0]        dt_r;
  logic [63:0]        prod_lo_r;
  logic [30:0]        f_r;
  logic [31:0]        term_r;
  logic [62:0]        p1_r;
  logic [31:0]        p_r;
  logic [63:0]        pm_r;
  logic signed [33:0] sum_r;
  logic [3:0]         k_r;
  logic [31:0]        v_r;
  logic [1:0]         sq_r;
  logic [16:0]        factor_r;

  logic [35:0] hi_w;
  logic [68:0] e_w;
  logic [31:0] q0_w, q_w;
  logic [35:0] rem_w;
  logic [63:0] sqp_w;
  logic [32:0] rnd_w;

  assign hi_w  = 36'(rate) * 36'(dt_r[35:32]);
  assign e_w   = 69'(prod_lo_r) + 69'({hi_w, 32'd0});
  assign q0_w  = pm_r[62:31];
  assign rem_w = 36'(p_r) - 36'(q0_w) * 36'(k_r);
  assign q_w   = (rem_w >= 36'(k_r)) ? q0_w + 32'd1 : q0_w;
  assign sqp_w = 64'(v_r) * 64'(v_r) + 64'd1073741824;
  assign rnd_w = 33'(v_r) + 33'd16384;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          if (rate == 32'd0 || dt == 48'd0 || dt[47:36] != 12'd0) state_nxt = D_DONE;
          else state_nxt = D_E1;
        end
      end
      D_E1:    state_nxt = D_E2;
      D_E2:    state_nxt = (e_w[68:36] != 33'd0) ? D_DONE : D_T1;
      D_T1:    state_nxt = D_T2;
      D_T2:    state_nxt = D_T3;
      D_T3:    state_nxt = (k_r == 4'(TERMS)) ? D_CLAMP : D_T1;
      D_CLAMP: state_nxt = D_SQ;
      D_SQ:    state_nxt = (sq_r == 2'd3) ? D_RND : D_SQ;
      D_RND:   state_nxt = D_DONE;
      D_DONE:  state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      D_IDLE: begin
        dt_r <= dt[35:0];
        if (rate == 32'd0 || dt == 48'd0) factor_r <= 17'd65536;
        else factor_r <= 17'd0;
      end
      D_E1: prod_lo_r <= 64'(rate) * 64'(dt_r[31:0]);
      D_E2: begin
        f_r      <= e_w[35:5];
        term_r   <= 32'd2147483648;
        sum_r    <= ONE_Q31;
        k_r      <= 4'd1;
        factor_r <= 17'd0;
      end
      D_T1: p1_r <= 63'(term_r) * 63'(f_r);
      D_T2: begin
        p_r  <= p1_r[62:31];
        pm_r <= 64'(p1_r[62:31]) * 64'(recip(k_r));
      end
      D_T3: begin
        term_r <= q_w;
        if (k_r[0]) sum_r <= sum_r - $signed({2'b00, q_w});
        else sum_r <= sum_r + $signed({2'b00, q_w});
        k_r <= k_r + 4'd1;
      end
      D_CLAMP: begin
        if (sum_r < 34'sd0) v_r <= 32'd0;
        else if (sum_r > ONE_Q31) v_r <= 32'd2147483648;
        else v_r <= sum_r[31:0];
        sq_r <= 2'd0;
      end
      D_SQ: begin
        v_r  <= sqp_w[62:31];
        sq_r <= sq_r + 2'd1;
      end
      D_RND: factor_r <= rnd_w[31:15];
      default: ;
    endcase
  end

  assign done   = (state_r == D_DONE);
  assign factor = factor_r;

endmodule

// ===== hw/rtl/edc_datapath.sv =====
// Datapath: config registers, running time, surface memory, cell update and output register.
module edc_datapath #(
  parameter int WIDTH   = 640,
  parameter int HEIGHT  = 480,
  parameter int KSIZE   = 3,
  parameter int TS_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  edc_pkg::cmd_t                       cmd,
  output edc_pkg::stat_t                      stat,
  input  logic [edc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_we,
  input  logic [edc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [edc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [edc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);
  import edc_pkg::*;

  localparam int PAD_W  = WIDTH + KSIZE - 1;
  localparam int PAD_H  = HEIGHT + KSIZE - 1;
  localparam int CELLS  = PAD_W * PAD_H;
  localparam int AW     = $clog2(CELLS);
  localparam int KW     = (KSIZE > 1) ? $clog2(KSIZE) : 1;
  localparam int HALF_K = (KSIZE - 1) / 2;
  localparam int ENT_W  = TIME_W + VALUE_W;

  localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
  localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

  logic [31:0]          rate_r;
  logic [15:0]          taps_r [4];
  logic [9:0]           x_r;
  logic [8:0]           y_r;
  logic                 pol_r;
  logic [TIME_W-1:0]    now_r;
  logic [TS_BITS-1:0]   prev_r;
  logic [KW-1:0]        i_r, j_r;
  logic [AW-1:0]        addr_r, clr_addr_r;
  logic [ENT_W-1:0]     rd_r;
  logic signed [49:0]   prod_r;
  logic [15:0]          w_r;
  logic [31:0]          val_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_last_r, out_valid_r;

  logic [ENT_W-1:0]     mem [CELLS];

  logic [TS_BITS-1:0]   stamp_w, diff_w;
  logic [11:0]          cx_w, cy_w;
  logic [15:0]          tap_i_w, tap_j_w;
  logic [31:0]          wprod_w;
  logic signed [49:0]   val_ext_w, fac_ext_w, rnd_w, sum_w;
  logic [31:0]          sat_w;
  logic [47:0]          dt_w;
  logic                 decay_done;
  logic [16:0]          factor;
  logic                 last_cell_w;

  function automatic logic [15:0] tap_at(input logic [KW-1:0] pos,
                                         input logic [15:0] t0, input logic [15:0] t1,
                                         input logic [15:0] t2, input logic [15:0] t3);
    logic [3:0]  p4;
    logic [3:0]  d4;
    logic [15:0] t;
    p4 = 4'(pos);
    d4 = (p4 >= 4'(HALF_K)) ? p4 - 4'(HALF_K) : 4'(HALF_K) - p4;
    case (d4[1:0])
      2'd0:    t = t0;
      2'd1:    t = t1;
      2'd2:    t = t2;
      default: t = t3;
    endcase
    return t;
  endfunction

  assign stamp_w   = TS_BITS'(in_tdata[42:19]);
  assign diff_w    = stamp_w - prev_r;
  assign cx_w      = 12'(x_r) + 12'(j_r);
  assign cy_w      = 12'(y_r) + 12'(i_r);
  assign tap_i_w   = tap_at(i_r, taps_r[0], taps_r[1], taps_r[2], taps_r[3]);
  assign tap_j_w   = tap_at(j_r, taps_r[0], taps_r[1], taps_r[2], taps_r[3]);
  assign wprod_w   = 32'(tap_i_w) * 32'(tap_j_w);
  assign val_ext_w = 50'($signed(rd_r[VALUE_W-1:0]));
  assign fac_ext_w = $signed({33'd0, factor});
  assign rnd_w     = (prod_r + 50'sd32768) >>> 16;
  assign sum_w     = pol_r ? rnd_w + $signed({34'd0, w_r}) : rnd_w - $signed({34'd0, w_r});
  assign dt_w      = now_r - rd_r[ENT_W-1:VALUE_W];
  assign last_cell_w = (i_r == KW'(KSIZE - 1)) && (j_r == KW'(KSIZE - 1));

  always_comb begin
    if (sum_w > SAT_MAX) sat_w = 32'h7FFF_FFFF;
    else if (sum_w < SAT_MIN) sat_w = 32'h8000_0000;
    else sat_w = sum_w[31:0];
  end

  edc_decay u_decay (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start_decay),
    .dt     (dt_w),
    .rate   (rate_r),
    .done   (decay_done),
    .factor (factor)
  );

  // surface store: cell time in the upper bits, value in the lower bits
  always_ff @(posedge clk) begin
    if (cmd.clear) mem[clr_addr_r] <= '0;
    else if (cmd.finish) mem[addr_r] <= {now_r, sat_w};
    if (cmd.mem_read) rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= 32'd1080;
      taps_r[0]   <= 16'd65033;
      taps_r[1]   <= 16'd251;
      taps_r[2]   <= 16'd0;
      taps_r[3]   <= 16'd0;
      now_r       <= '0;
      prev_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DECAY_RATE: rate_r    <= cfg_data;
          CFG_TAP_CENTER: taps_r[0] <= cfg_data[15:0];
          CFG_TAP_ONE:    taps_r[1] <= cfg_data[15:0];
          CFG_TAP_TWO:    taps_r[2] <= cfg_data[15:0];
          CFG_TAP_THREE:  taps_r[3] <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.clear) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.load_event) begin
        now_r  <= now_r + TIME_W'(diff_w);
        prev_r <= stamp_w;
        i_r    <= '0;
        j_r    <= '0;
      end
      if (cmd.advance) begin
        if (j_r == KW'(KSIZE - 1)) begin
          j_r <= '0;
          i_r <= i_r + KW'(1);
        end else begin
          j_r <= j_r + KW'(1);
        end
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      x_r   <= in_tdata[9:0];
      y_r   <= in_tdata[18:10];
      pol_r <= in_tuser;
    end
    if (cmd.calc_addr) addr_r <= AW'(32'(cy_w) * 32'(PAD_W) + 32'(cx_w));
    if (cmd.mul) begin
      prod_r <= val_ext_w * fac_ext_w;
      w_r    <= wprod_w[31:16];
    end
    if (cmd.finish) val_r <= sat_w;
    if (cmd.emit) begin
      out_data_r <= {5'd0, val_r, cy_w[8:0], cx_w[9:0]};
      out_last_r <= last_cell_w;
    end
  end

  assign stat.clear_last = (clr_addr_r == AW'(CELLS - 1));
  assign stat.in_range   = (32'(x_r) <= 32'(WIDTH - 1)) && (32'(y_r) <= 32'(HEIGHT - 1));
  assign stat.decay_done = decay_done;
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.last_cell  = last_cell_w;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/edc_ctrl.sv =====
// Controller: clearing pass, event intake and per-cell sequencing.
module edc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output edc_pkg::cmd_t  cmd,
  input  edc_pkg::stat_t stat
);
  import edc_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_ADDR  = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_DT    = 4'd5;
  localparam logic [3:0] S_DECAY = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_event = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: state_nxt = stat.in_range ? S_ADDR : S_IDLE;
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_DT;
      end
      S_DT: begin
        cmd.start_decay = 1'b1;
        state_nxt       = S_DECAY;
      end
      S_DECAY: if (stat.decay_done) state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_cell) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_ADDR;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/event_decay_convolution.sv =====
// Top level of the exponentially decaying event convolution surface.
//
// Usage:
//  - in_ beats carry one camera event each; every in-range event produces
//    KSIZE*KSIZE out_ beats, one per padded cell of its patch, row-major,
//    out_tlast high on the final cell. Off-surface events only advance time.
//  - cfg_we writes decay_rate (index 0) or a tap (indexes 1..4) at once;
//    write only while the block is idle. Other indexes are ignored.
//  - Per cell: address, memory read, decay unit, multiply, saturate, emit.
//    The decay unit is the long step: when the exponent is in range it forms
//    two partial products, works 14 Taylor terms, clamps, does four
//    squarings and rounds; it skips these when rate or age is zero or the
//    factor underflows. Each event runs intake, a range check, then its
//    KSIZE*KSIZE cells; one event is worked at a time.
//  - After reset the surface store is cleared one entry a cycle, all
//    (WIDTH+KSIZE-1)*(HEIGHT+KSIZE-1) entries, 309444 at the defaults;
//    in_tready stays low meanwhile, config writes are still taken.
//  - A stalled receiver holds the current cell in the output register;
//    sequencing waits at the emit step until that beat is taken.
module event_decay_convolution #(
  parameter int WIDTH   = 640,
  parameter int HEIGHT  = 480,
  parameter int KSIZE   = 3,
  parameter int TS_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // event_x[9:0], event_y[18:10], stamp[42:19], zero fill
  input  logic [edc_pkg::IN_DATA_W-1:0]  in_tdata,
  // polarity[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // cell_x[9:0], cell_y[18:10], cell_value[50:19], zero fill
  output logic [edc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [edc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import edc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  edc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  edc_datapath #(
    .WIDTH   (WIDTH),
    .HEIGHT  (HEIGHT),
    .KSIZE   (KSIZE),
    .TS_BITS (TS_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the event decay convolution surface block.
module tb;
  import edc_pkg::*;

  localparam int WIDTH   = 640;
  localparam int HEIGHT  = 480;
  localparam int KSIZE   = 3;
  localparam int TS_BITS = 24;
  localparam int PAD_W   = WIDTH + KSIZE - 1;
  localparam longint unsigned TIME_MASK  = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned STAMP_MASK = (64'd1 << TS_BITS) - 1;
  // Settling wait after the queues empty; long enough for an off-surface event in flight.
  localparam int DRAIN_CYCLES = 600;
  // Clearing pass of 309444 entries plus slow items under heavy stalls, several times over.
  localparam int CYCLE_LIMIT  = 4000000;

  typedef struct {
    logic [9:0]  x;
    logic [8:0]  y;
    logic        pol;
    logic [23:0] stamp;
  } event_t;

  // One updated cell the block owes us; value is worked out when it arrives.
  typedef struct {
    logic [9:0]        cx;
    logic [8:0]        cy;
    logic              pol;
    longint            weight;
    longint unsigned   now;
    logic              last;
  } cell_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  event_decay_convolution uut (.*);

  // Predictor state: registers, running time, sparse surface (absent = zero).
  logic [31:0]     rate;
  logic [15:0]     taps [4];
  longint unsigned now_time, prev_stamp;
  int              surf_value [int];
  longint unsigned surf_time  [int];

  event_t pending_events [$];
  cell_t  owed_cells [$];
  event_t cur_event;
  int errors, cycles;
  int in_idle_pct, out_idle_pct;
  logic [23:0] stamp_run;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("event_decay_convolution test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // exp(-rate*dt/2^32) in Q1.16, Taylor series then four squarings
  function automatic longint unsigned decay_q16(input longint unsigned dt);
    longint unsigned r, e, f, term, v;
    longint sum;
    int k;
    r = rate;
    dt &= TIME_MASK;
    if (r == 0 || dt == 0) return 65536;
    if (dt > ((64'd1 << 36) - 1) / r) return 0;
    e = r * dt;
    f = e >> 5;
    sum = 64'sd1 <<< 31;
    term = 64'd1 << 31;
    for (k = 1; k <= 14; k++) begin
      term = ((term * f) >> 31) / k;
      if (k & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 31)) sum = 64'sd1 <<< 31;
    v = sum;
    for (k = 0; k < 4; k++) v = (v * v + (64'd1 << 30)) >> 31;
    return (v + (64'd1 << 14)) >> 15;
  endfunction

  // decay, add or remove the kernel weight, saturate to 32 bits
  function automatic longint cell_update(input int value, input longint d, input cell_t c);
    longint p, v;
    p = longint'(value) * d + 32768;
    if (p >= 0) v = p >>> 16;
    else v = -longint'((unsigned'(-p) + 65535) >> 16);
    v = c.pol ? v + c.weight : v - c.weight;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [15:0] tap_for(input int pos);
    int d;
    d = pos - (KSIZE - 1) / 2;
    if (d < 0) d = -d;
    return taps[d & 3];
  endfunction

  // Advance time for an accepted event and list the cells it will touch.
  task automatic predict_event(input event_t ev);
    cell_t c;
    longint unsigned st;
    st = ev.stamp & STAMP_MASK;
    now_time = (now_time + ((st - prev_stamp) & STAMP_MASK)) & TIME_MASK;
    prev_stamp = st;
    if (ev.x > WIDTH - 1 || ev.y > HEIGHT - 1) return;
    for (int i = 0; i < KSIZE; i++)
      for (int j = 0; j < KSIZE; j++) begin
        c.cx = 10'(ev.x + j);
        c.cy = 9'(ev.y + i);
        c.pol = ev.pol;
        c.weight = (longint'(tap_for(i)) * longint'(tap_for(j))) >>> 16;
        c.now = now_time;
        c.last = (i == KSIZE - 1 && j == KSIZE - 1);
        owed_cells = {owed_cells, c};
      end
  endtask

  // Decay factor may be off by one LSB in hardware: accept the span it gives.
  task automatic check_cell(input logic [9:0] gx, input logic [8:0] gy,
                            input logic signed [31:0] gv, input logic glast);
    cell_t c;
    int idx, old;
    longint d, lo, hi, v, want;
    if (owed_cells.size() == 0) begin
      report_mismatch("unexpected beat, cell_x", longint'(gx), -1);
      return;
    end
    c = owed_cells.pop_front();
    if (gx !== c.cx) report_mismatch("cell_x", gx, c.cx);
    if (gy !== c.cy) report_mismatch("cell_y", gy, c.cy);
    if (glast !== c.last) report_mismatch("last", glast, c.last);
    idx = int'(c.cy) * PAD_W + int'(c.cx);
    old = surf_value.exists(idx) ? surf_value[idx] : 0;
    d = decay_q16(c.now - (surf_time.exists(idx) ? surf_time[idx] : 0));
    want = cell_update(old, d, c);
    lo = want;
    hi = want;
    for (longint k = d - 1; k <= d + 1; k += 2)
      if (k >= 0 && k <= 65536) begin
        v = cell_update(old, k, c);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
    if ($isunknown(gv) || longint'(gv) < lo || longint'(gv) > hi) begin
      report_mismatch("cell_value", longint'(gv), want);
      surf_value[idx] = int'(want);
    end else begin
      surf_value[idx] = gv;
    end
    surf_time[idx] = c.now;
  endtask

  // Driver: one beat in flight, next beat chosen after each acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_event(cur_event);
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_event = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, cur_event.stamp, cur_event.y, cur_event.x};
          in_tuser <= cur_event.pol;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, check every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_cell(out_tdata[9:0], out_tdata[18:10], out_tdata[50:19], out_tlast);
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DECAY_RATE: rate = val;
      CFG_TAP_CENTER: taps[0] = val[15:0];
      CFG_TAP_ONE:    taps[1] = val[15:0];
      CFG_TAP_TWO:    taps[2] = val[15:0];
      CFG_TAP_THREE:  taps[3] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_event(input int x, input int y, input bit pol, input logic [23:0] st);
    event_t ev;
    ev.x = 10'(x);
    ev.y = 9'(y);
    ev.pol = pol;
    ev.stamp = st;
    pending_events = {pending_events, ev};
  endtask

  // Mostly a small busy corner so cells are hit again while still decaying.
  task automatic queue_random_event();
    int x, y, pick;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: stamp_run = stamp_run;
      1: stamp_run = 24'(stamp_run + $urandom_range(1, 20));
      2: stamp_run = 24'(stamp_run + $urandom_range(1, 200000));
      default: stamp_run = 24'($urandom);
    endcase
    if (pick < 70) begin
      x = $urandom_range(0, 6);
      y = $urandom_range(0, 6);
    end else if (pick < 80) begin
      x = $urandom_range(WIDTH - 4, WIDTH - 1);
      y = $urandom_range(HEIGHT - 4, HEIGHT - 1);
    end else if (pick < 88) begin
      x = $urandom_range(0, 1023);
      y = $urandom_range(HEIGHT, 511);
    end else begin
      x = $urandom_range(0, 1023);
      y = $urandom_range(0, 511);
    end
    queue_event(x, y, 1'($urandom_range(1)), stamp_run);
  endtask

  // Hold off until the block has nothing left for us, then let it settle.
  task automatic drain();
    while (!(pending_events.size() == 0 && !in_tvalid && owed_cells.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 38;
    out_idle_pct = 85;
    stamp_run = '0;
    rate = 32'd1080;
    taps[0] = 16'd65033;
    taps[1] = 16'd251;
    taps[2] = 16'd0;
    taps[3] = 16'd0;
    now_time = 0;
    prev_stamp = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        in_idle_pct = 85;
        out_idle_pct = 38;
      end else if (phase == 4) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      case (phase)
        0: begin
          write_reg(CFG_DECAY_RATE, 32'd1080);
          write_reg(CFG_TAP_CENTER, 32'd65033);
          write_reg(CFG_TAP_ONE, 32'd251);
          write_reg(CFG_TAP_TWO, 32'd0);
          write_reg(CFG_TAP_THREE, 32'd0);
        end
        1: begin
          // no decay, largest taps; indexes past the list must be ignored
          write_reg(CFG_DECAY_RATE, 32'd0);
          write_reg(CFG_TAP_CENTER, 32'hFFFF);
          write_reg(CFG_TAP_ONE, 32'hFFFF);
          write_reg(CFG_TAP_TWO, 32'hFFFF);
          write_reg(CFG_TAP_THREE, 32'hFFFF);
          write_reg(3'd5, 32'hFFFF_FFFF);
          write_reg(3'd7, 32'h1234_5678);
        end
        2: begin
          write_reg(CFG_DECAY_RATE, 32'hFFFF_FFFF);
          write_reg(CFG_TAP_CENTER, 32'd0);
          write_reg(CFG_TAP_ONE, $urandom_range(0, 65535));
          write_reg(CFG_TAP_TWO, 32'd0);
        end
        default: begin
          write_reg(CFG_DECAY_RATE, $urandom_range(1, 20000));
          write_reg(CFG_TAP_CENTER, $urandom_range(0, 65535));
          write_reg(CFG_TAP_ONE, $urandom_range(0, 65535));
          write_reg(CFG_TAP_TWO, $urandom_range(0, 65535));
          write_reg(CFG_TAP_THREE, $urandom_range(0, 65535));
        end
      endcase

      if (phase == 0) begin
        // corners, off-surface edges, repeated stamp, stamp wrap, both polarities
        queue_event(0, 0, 1, 24'd0);
        queue_event(0, 0, 1, 24'd0);
        queue_event(0, 0, 0, 24'd100);
        queue_event(WIDTH - 1, HEIGHT - 1, 1, 24'd5000);
        queue_event(WIDTH, 0, 1, 24'd6000);
        queue_event(0, HEIGHT, 0, 24'd7000);
        queue_event(1023, 511, 1, 24'hFFFFFF);
        queue_event(1, 1, 1, 24'hFFFFFF);
        queue_event(1, 1, 0, 24'd3);
        queue_event(2, 0, 1, 24'h800000);
        queue_event(WIDTH - 1, 0, 0, 24'h7FFFFF);
        queue_event(0, HEIGHT - 1, 1, 24'h7FFFFE);
        stamp_run = 24'h7FFFFE;
      end
      for (int n = 0; n < 43; n++) queue_random_event();
      drain();
    end

    if (errors == 0) begin
      $display("event_decay_convolution test passed");
    end else begin
      $display("event_decay_convolution test failed");
    end
    $finish;
  end

endmodule
